/* rtl/sm4bc_pkg.sv */
// SM4 block cipher shared definitions: S-box, FK constants, linear transforms, CK generator.
// Standalone package; used by the cipher core.
package sm4bc_pkg;

    localparam int unsigned NumRounds = 32;
    localparam int unsigned RkAddrW   = 5;
    localparam int unsigned WordW     = 32;

    localparam logic [WordW-1:0] FK0 = 32'hA3B1BAC6;
    localparam logic [WordW-1:0] FK1 = 32'h56AA3350;
    localparam logic [WordW-1:0] FK2 = 32'h677D9197;
    localparam logic [WordW-1:0] FK3 = 32'hB27022DC;

    localparam logic [7:0] SBOX [256] = '{
        8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
        8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
        8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
        8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
        8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
        8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
        8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
        8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
        8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
        8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
        8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
        8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
        8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
        8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
        8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
    };

    // Byte-wise S-box substitution (tau).
    function automatic logic [WordW-1:0] subst_word(input logic [WordW-1:0] x);
        subst_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    // L: b ^ b<<<2 ^ b<<<10 ^ b<<<18 ^ b<<<24
    function automatic logic [WordW-1:0] lin_round(input logic [WordW-1:0] b);
        lin_round = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                      ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    // L': b ^ b<<<13 ^ b<<<23
    function automatic logic [WordW-1:0] lin_key(input logic [WordW-1:0] b);
        lin_key = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

    // CK[i] byte j = (4i + j) * 7 mod 256
    function automatic logic [WordW-1:0] ck_word(input logic [RkAddrW-1:0] i);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        b0 = 8'({1'b0, i, 2'd0} * 8'd7);
        b1 = 8'({1'b0, i, 2'd1} * 8'd7);
        b2 = 8'({1'b0, i, 2'd2} * 8'd7);
        b3 = 8'({1'b0, i, 2'd3} * 8'd7);
        ck_word = {b0, b1, b2, b3};
    endfunction

endpackage

/* rtl/sm4bc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sm4bc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/sm4_block_cipher_core.sv */
// SM4 block cipher core: 128-bit key in APB registers, round keys cached in a 32x32 RAM.
// Depends on sm4bc_pkg and sm4bc_ram.
// Per block: key expansion into the RAM first when the round keys are stale, then a
//   round-key prefetch, 32 rounds on the shared S-box/linear datapath, and the idle
//   cycle that carries the done beat, in which the next block can already be accepted.
// Reset: asynchronous, active low; clears the key, marks round keys stale, goes idle.
// The result beat lasts one cycle on done; the receiver cannot stall it.
module sm4_block_cipher_core (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    // result channel
    output logic        done,
    output logic [63:0] out_high,
    output logic [63:0] out_low,
    // configuration (APB style): key_high at 0x0, key_low at 0x8
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int unsigned AW = sm4bc_pkg::RkAddrW;
    localparam int unsigned WW = sm4bc_pkg::WordW;

    // sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_KEXP  = 2'd1;   // one round key per cycle into the RAM
    localparam logic [1:0] ST_PREF  = 2'd2;   // fetch first round key
    localparam logic [1:0] ST_ROUND = 2'd3;   // one cipher round per cycle

    localparam logic [AW-1:0] LAST_IDX = AW'(sm4bc_pkg::NumRounds - 1);

    // register select: bit 3 of the byte address picks the 64-bit key half
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          ready_reg, ready_next;     // round keys in RAM match the key
    logic          done_reg, done_next;
    logic          dec_reg, dec_next;
    logic [63:0]   key_high_reg, key_low_reg;

    // block words X0..X3 and key schedule words K0..K3
    logic [WW-1:0] x_reg [4];
    logic [WW-1:0] x_next [4];
    logic [WW-1:0] k_reg [4];
    logic [WW-1:0] k_next [4];
    logic [63:0]   out_high_reg, out_high_next;
    logic [63:0]   out_low_reg, out_low_next;

    // round key RAM
    logic          rk_we;
    logic [AW-1:0] rk_raddr, rd_idx;
    logic [WW-1:0] rk_rdata;

    // shared datapath
    logic [WW-1:0] sub_in, sub_out, mix_out, new_word;

    logic accept, cfg_wr;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign out_high = out_high_reg;
    assign out_low  = out_low_reg;
    assign pready   = 1'b1;

    always_comb
    begin
        unique case (paddr[3])
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_KEY_LOW:  prdata = key_low_reg;
            default:      prdata = key_high_reg;
        endcase
    end

    // key registers; any write marks the cached round keys stale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == REG_KEY_HIGH)
            begin
                key_high_reg <= pwdata;
            end
            else
            begin
                key_low_reg <= pwdata;
            end
        end
    end

    // One S-box bank and XOR tree serve both key expansion (L') and rounds (L).
    assign sub_in  = (state_reg == ST_KEXP)
                   ? (k_reg[1] ^ k_reg[2] ^ k_reg[3] ^ sm4bc_pkg::ck_word(cnt_reg))
                   : (x_reg[1] ^ x_reg[2] ^ x_reg[3] ^ rk_rdata);
    assign sub_out = sm4bc_pkg::subst_word(sub_in);
    assign mix_out = (state_reg == ST_KEXP) ? sm4bc_pkg::lin_key(sub_out)
                                            : sm4bc_pkg::lin_round(sub_out);
    assign new_word = ((state_reg == ST_KEXP) ? k_reg[0] : x_reg[0]) ^ mix_out;

    // read one key ahead of the round that uses it; decrypt walks 31..0 (~i)
    assign rd_idx   = (state_reg == ST_ROUND) ? (cnt_reg + AW'(1)) : cnt_reg;
    assign rk_raddr = dec_reg ? ~rd_idx : rd_idx;
    assign rk_we    = (state_reg == ST_KEXP);

    sm4bc_ram #(
        .WIDTH (WW),
        .DEPTH (sm4bc_pkg::NumRounds)
    ) u_rk_ram (
        .clk   (clk),
        .we    (rk_we),
        .waddr (cnt_reg),
        .wdata (new_word),
        .raddr (rk_raddr),
        .rdata (rk_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ready_next    = ready_reg;
        done_next     = 1'b0;
        dec_next      = dec_reg;
        x_next        = x_reg;
        k_next        = k_reg;
        out_high_next = out_high_reg;
        out_low_next  = out_low_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dec_next  = cmd;
                    cnt_next  = '0;
                    x_next[0] = block_high[63:32];
                    x_next[1] = block_high[31:0];
                    x_next[2] = block_low[63:32];
                    x_next[3] = block_low[31:0];
                    k_next[0] = key_high_reg[63:32] ^ sm4bc_pkg::FK0;
                    k_next[1] = key_high_reg[31:0]  ^ sm4bc_pkg::FK1;
                    k_next[2] = key_low_reg[63:32]  ^ sm4bc_pkg::FK2;
                    k_next[3] = key_low_reg[31:0]   ^ sm4bc_pkg::FK3;
                    state_next = ready_reg ? ST_PREF : ST_KEXP;
                end
            end
            ST_KEXP:
            begin
                k_next[0] = k_reg[1];
                k_next[1] = k_reg[2];
                k_next[2] = k_reg[3];
                k_next[3] = new_word;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    // last write lands at this edge; first read issues next cycle
                    ready_next = 1'b1;
                    state_next = ST_PREF;
                end
            end
            ST_PREF:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                x_next[0] = x_reg[1];
                x_next[1] = x_reg[2];
                x_next[2] = x_reg[3];
                x_next[3] = new_word;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    // reverse word order: {X35, X34} {X33, X32}
                    out_high_next = {new_word, x_reg[3]};
                    out_low_next  = {x_reg[2], x_reg[1]};
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // key write is only legal while idle; its stale mark wins over the ready set by key expansion
        if (cfg_wr)
        begin
            ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ready_reg <= 1'b0;
            done_reg  <= 1'b0;
            dec_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ready_reg <= ready_next;
            done_reg  <= done_next;
            dec_reg   <= dec_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        k_reg        <= k_next;
        out_high_reg <= out_high_next;
        out_low_reg  <= out_low_next;
    end

endmodule

/* rtl/sm4bc_checker.sv */
// Port-level checker for the SM4 core command/result handshake, with its bind.
// Depends on sm4_block_cipher_core ports only.
module sm4bc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // a result beat only ends a run
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a preceding busy cycle");

    // the core is free again when the result shows
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy still high during result beat");

    // an accepted command starts a run
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but core not busy");

    // a result beat is never followed directly by another
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat longer than one cycle");

endmodule

bind sm4_block_cipher_core sm4bc_checker u_sm4bc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
